// ===== rtl/ucd_pkg.sv =====
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared item types, command codes and controller states of the undirected
// cycle detector.
// ----------------------------------------------------------------------------
package ucd_pkg;

    localparam int VERTEX_W = 10;
    localparam int COUNT_W  = 11;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic                command;
        logic [VERTEX_W-1:0] from_vertex;
        logic [VERTEX_W-1:0] to_vertex;
    } in_item_t;

    typedef struct packed {
        logic has_cycle;
        logic load_error;
    } out_item_t;

    typedef struct packed {
        logic      done;
        out_item_t item;
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PUSH,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_VIS_CHK,
        S_POP
    } state_t;

endpackage

// ===== rtl/ucd_ram.sv =====
// ----------------------------------------------------------------------------
// ucd_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module ucd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ucd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ucd_ctrl
// Loads adjacency entries into linked lists and runs the depth-first walk
// over the list, visited, entry and stack memories.
// ----------------------------------------------------------------------------
module ucd_ctrl #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_ENTRIES  = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ucd_pkg::in_item_t                    in_item,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]    n,
    input  logic                                 out_busy,
    output ucd_pkg::status_t                     status
);

    localparam int VA = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int EA = $clog2(MAX_ENTRIES);
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int LW = 2 * EW;
    localparam int FW = 2 * VA + 1 + 2 * EW;
    localparam logic [EW-1:0] NULL_LINK = EW'(MAX_ENTRIES);

    ucd_pkg::state_t state_reg, state_next;
    logic [VA-1:0] clr_addr_reg, clr_addr_next;
    logic [NW-1:0] root_reg, root_next;
    logic [NW-1:0] depth_reg, depth_next;
    logic [VA-1:0] top_vertex_reg, top_vertex_next;
    logic [VA-1:0] top_parent_reg, top_parent_next;
    logic          top_pvalid_reg, top_pvalid_next;
    logic [EW-1:0] top_cursor_reg, top_cursor_next;
    logic [EW-1:0] top_tail_reg, top_tail_next;
    logic [VA-1:0] nb_reg, nb_next;
    logic [VA-1:0] push_vertex_reg, push_vertex_next;
    logic [VA-1:0] push_parent_reg, push_parent_next;
    logic          push_pvalid_reg, push_pvalid_next;
    logic          err_reg, err_next;
    logic [EW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    logic          cycle_reg, cycle_next;
    logic          errout_reg, errout_next;
    logic          s2_valid_reg, s2_valid_next;
    logic [VA-1:0] s2_from_reg, s2_from_next;
    logic [VA-1:0] s2_to_reg, s2_to_next;
    logic [EW-1:0] s2_e_reg, s2_e_next;
    logic          fwd_valid_reg, fwd_valid_next;
    logic [VA-1:0] fwd_addr_reg, fwd_addr_next;
    logic [LW-1:0] fwd_data_reg, fwd_data_next;

    logic          list_we;
    logic [VA-1:0] list_waddr, list_raddr;
    logic [LW-1:0] list_wdata, list_rdata;
    logic          vis_we, vis_wdata, vis_rdata;
    logic [VA-1:0] vis_waddr, vis_raddr;
    logic          nbr_we;
    logic [VA-1:0] nbr_rdata;
    logic          next_we;
    logic [EA-1:0] next_waddr;
    logic [EW-1:0] next_rdata;
    logic [EA-1:0] entry_raddr;
    logic          stk_we;
    logic [VA-1:0] stk_waddr, stk_raddr;
    logic [FW-1:0] stk_wdata, stk_rdata;

    logic          accept;
    logic          add_ok;
    logic          root_last;
    logic [LW-1:0] s2_list;
    logic [EW-1:0] s2_head, s2_tail;
    logic [EW-1:0] cursor_adv;

    ucd_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_list (
        .clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
        .raddr(list_raddr), .rdata(list_rdata)
    );

    ucd_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_visited (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );

    ucd_ram #(.WIDTH(VA), .DEPTH(MAX_ENTRIES)) u_nbr (
        .clk(clk), .we(nbr_we), .waddr(EA'(s2_e_reg)), .wdata(s2_to_reg),
        .raddr(entry_raddr), .rdata(nbr_rdata)
    );

    ucd_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_next (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(s2_e_reg),
        .raddr(entry_raddr), .rdata(next_rdata)
    );

    ucd_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ucd_pkg::S_CLEAR;
            clr_addr_reg  <= '0;
            root_reg      <= '0;
            depth_reg     <= '0;
            err_reg       <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            root_reg      <= root_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            s2_valid_reg  <= s2_valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_vertex_reg  <= top_vertex_next;
        top_parent_reg  <= top_parent_next;
        top_pvalid_reg  <= top_pvalid_next;
        top_cursor_reg  <= top_cursor_next;
        top_tail_reg    <= top_tail_next;
        nb_reg          <= nb_next;
        push_vertex_reg <= push_vertex_next;
        push_parent_reg <= push_parent_next;
        push_pvalid_reg <= push_pvalid_next;
        cycle_reg       <= cycle_next;
        errout_reg      <= errout_next;
        s2_from_reg     <= s2_from_next;
        s2_to_reg       <= s2_to_next;
        s2_e_reg        <= s2_e_next;
        fwd_addr_reg    <= fwd_addr_next;
        fwd_data_reg    <= fwd_data_next;
    end

    // Append stage: the list word of the previous item is forwarded when
    // both items go to the same vertex.
    always_comb
    begin
        s2_list = (fwd_valid_reg && fwd_addr_reg == s2_from_reg) ? fwd_data_reg : list_rdata;
        s2_head = s2_list[LW-1:EW];
        s2_tail = s2_list[EW-1:0];
    end

    always_comb
    begin
        in_stall  = (state_reg != ucd_pkg::S_IDLE)
                    || (in_item.command == ucd_pkg::CMD_FINISH && out_busy);
        accept    = in_valid && !in_stall;
        add_ok    = (32'(in_item.from_vertex) < 32'(n)) && (32'(in_item.to_vertex) < 32'(n))
                    && (count_reg != NULL_LINK);
        root_last = (32'(root_reg) + 32'd1) >= 32'(n);
        cursor_adv = (top_cursor_reg == top_tail_reg) ? NULL_LINK : next_rdata;

        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        root_next        = root_reg;
        depth_next       = depth_reg;
        top_vertex_next  = top_vertex_reg;
        top_parent_next  = top_parent_reg;
        top_pvalid_next  = top_pvalid_reg;
        top_cursor_next  = top_cursor_reg;
        top_tail_next    = top_tail_reg;
        nb_next          = nb_reg;
        push_vertex_next = push_vertex_reg;
        push_parent_next = push_parent_reg;
        push_pvalid_next = push_pvalid_reg;
        err_next         = err_reg;
        count_next       = count_reg;
        done_next        = 1'b0;
        cycle_next       = cycle_reg;
        errout_next      = errout_reg;

        s2_valid_next  = 1'b0;
        s2_from_next   = VA'(in_item.from_vertex);
        s2_to_next     = VA'(in_item.to_vertex);
        s2_e_next      = count_reg;
        fwd_valid_next = s2_valid_reg;
        fwd_addr_next  = s2_from_reg;
        fwd_data_next  = {(s2_tail == NULL_LINK) ? s2_e_reg : s2_head, s2_e_reg};

        list_we     = s2_valid_reg;
        list_waddr  = s2_from_reg;
        list_wdata  = fwd_data_next;
        list_raddr  = VA'(in_item.from_vertex);
        nbr_we      = s2_valid_reg;
        next_we     = s2_valid_reg && (s2_tail != NULL_LINK);
        next_waddr  = EA'(s2_tail);
        vis_we      = 1'b0;
        vis_waddr   = nb_reg;
        vis_wdata   = 1'b1;
        vis_raddr   = VA'(root_reg);
        entry_raddr = EA'(top_cursor_reg);
        stk_we      = 1'b0;
        stk_waddr   = VA'(depth_reg - NW'(1));
        stk_wdata   = {top_vertex_reg, top_parent_reg, top_pvalid_reg,
                       top_cursor_reg, top_tail_reg};
        stk_raddr   = VA'(depth_reg - NW'(2));

        case (state_reg)
            ucd_pkg::S_CLEAR:
            begin
                list_we    = 1'b1;
                list_waddr = clr_addr_reg;
                list_wdata = {NULL_LINK, NULL_LINK};
                vis_we     = 1'b1;
                vis_waddr  = clr_addr_reg;
                vis_wdata  = 1'b0;
                clr_addr_next = clr_addr_reg + VA'(1);
                if (clr_addr_reg == VA'(MAX_VERTICES - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = ucd_pkg::S_IDLE;
                end
            end
            ucd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.command == ucd_pkg::CMD_FINISH)
                    begin
                        root_next  = '0;
                        depth_next = '0;
                        state_next = ucd_pkg::S_SCAN_RD;
                    end
                    else if (add_ok)
                    begin
                        s2_valid_next = 1'b1;
                        count_next    = count_reg + EW'(1);
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            ucd_pkg::S_SCAN_RD:
            begin
                state_next = ucd_pkg::S_SCAN_CHK;
            end
            ucd_pkg::S_SCAN_CHK:
            begin
                if (!vis_rdata)
                begin
                    vis_we           = 1'b1;
                    vis_waddr        = VA'(root_reg);
                    list_raddr       = VA'(root_reg);
                    push_vertex_next = VA'(root_reg);
                    push_pvalid_next = 1'b0;
                    state_next       = ucd_pkg::S_PUSH;
                end
                else if (root_last)
                begin
                    done_next   = 1'b1;
                    cycle_next  = 1'b0;
                    errout_next = err_reg;
                    state_next  = ucd_pkg::S_CLEAR;
                end
                else
                begin
                    root_next  = root_reg + NW'(1);
                    state_next = ucd_pkg::S_SCAN_RD;
                end
            end
            ucd_pkg::S_PUSH:
            begin
                top_vertex_next = push_vertex_reg;
                top_parent_next = push_parent_reg;
                top_pvalid_next = push_pvalid_reg;
                top_cursor_next = list_rdata[LW-1:EW];
                top_tail_next   = list_rdata[EW-1:0];
                depth_next      = depth_reg + NW'(1);
                state_next      = ucd_pkg::S_EDGE_RD;
            end
            ucd_pkg::S_EDGE_RD:
            begin
                if (top_cursor_reg != NULL_LINK)
                begin
                    state_next = ucd_pkg::S_EDGE_CHK;
                end
                else if (depth_reg == NW'(1))
                begin
                    depth_next = '0;
                    if (root_last)
                    begin
                        done_next   = 1'b1;
                        cycle_next  = 1'b0;
                        errout_next = err_reg;
                        state_next  = ucd_pkg::S_CLEAR;
                    end
                    else
                    begin
                        root_next  = root_reg + NW'(1);
                        state_next = ucd_pkg::S_SCAN_RD;
                    end
                end
                else
                begin
                    depth_next = depth_reg - NW'(1);
                    state_next = ucd_pkg::S_POP;
                end
            end
            ucd_pkg::S_EDGE_CHK:
            begin
                top_cursor_next = cursor_adv;
                if (32'(nbr_rdata) >= 32'(n))
                begin
                    err_next   = 1'b1;
                    state_next = ucd_pkg::S_EDGE_RD;
                end
                else
                begin
                    vis_raddr  = nbr_rdata;
                    nb_next    = nbr_rdata;
                    state_next = ucd_pkg::S_VIS_CHK;
                end
            end
            ucd_pkg::S_VIS_CHK:
            begin
                if (!vis_rdata)
                begin
                    stk_we           = 1'b1;
                    vis_we           = 1'b1;
                    list_raddr       = nb_reg;
                    push_vertex_next = nb_reg;
                    push_parent_next = top_vertex_reg;
                    push_pvalid_next = 1'b1;
                    state_next       = ucd_pkg::S_PUSH;
                end
                else if (!(top_pvalid_reg && nb_reg == top_parent_reg))
                begin
                    done_next   = 1'b1;
                    cycle_next  = 1'b1;
                    errout_next = err_reg;
                    state_next  = ucd_pkg::S_CLEAR;
                end
                else
                begin
                    state_next = ucd_pkg::S_EDGE_RD;
                end
            end
            ucd_pkg::S_POP:
            begin
                {top_vertex_next, top_parent_next, top_pvalid_next,
                 top_cursor_next, top_tail_next} = stk_rdata;
                state_next = ucd_pkg::S_EDGE_RD;
            end
            default:
            begin
                state_next = ucd_pkg::S_CLEAR;
            end
        endcase

        if (done_next)
        begin
            err_next   = 1'b0;
            count_next = '0;
        end
    end

    assign status.done            = done_reg;
    assign status.item.has_cycle  = cycle_reg;
    assign status.item.load_error = errout_reg;

endmodule

// ===== rtl/undirected_cycle_detect.sv =====
// ----------------------------------------------------------------------------
// undirected_cycle_detect
// Undirected graph cycle detector with a depth-first walk over linked
// adjacency lists held in memory.
// ----------------------------------------------------------------------------
// While the block is idle, an add item is taken every cycle and appended to
// its vertex list in memory. A finish item starts the walk: it scans the
// vertices for an unvisited root, follows adjacency entries, pushes each
// newly visited vertex and pops a vertex whose entries are done; the list,
// visited, entry and stack memories all have registered reads. After the
// result the block clears its list and visited memories, as it also does
// after reset; no item is taken during that pass. A finish waits while an
// earlier result is still untaken.
module undirected_cycle_detect #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_ENTRIES  = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ucd_pkg::COUNT_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ucd_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ucd_pkg::out_item_t                 out_item
);

    localparam int NW = $clog2(MAX_VERTICES + 1);

    logic [ucd_pkg::COUNT_W-1:0] count_cfg_reg;
    logic [NW-1:0]               n;
    logic                        out_valid_reg;
    ucd_pkg::out_item_t          out_item_reg;
    ucd_pkg::status_t            status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= ucd_pkg::COUNT_W'(1024);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                count_cfg_reg <= cfg_data;
            end
            if (status.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            out_item_reg <= status.item;
        end
    end

    always_comb
    begin
        if (count_cfg_reg == '0)
        begin
            n = NW'(1);
        end
        else if (32'(count_cfg_reg) > 32'(MAX_VERTICES))
        begin
            n = NW'(MAX_VERTICES);
        end
        else
        begin
            n = NW'(count_cfg_reg);
        end
    end

    ucd_ctrl #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item (in_item),
        .n       (n),
        .out_busy(out_valid_reg),
        .status  (status)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/ucd_checker.sv =====
// ----------------------------------------------------------------------------
// ucd_checker
// Port-level checks of the undirected cycle detector, bound to the top level.
// ----------------------------------------------------------------------------
module ucd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input ucd_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_stall,
    input ucd_pkg::out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("result item changed while stalled");

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.command == ucd_pkg::CMD_FINISH |=> in_stall)
        else $error("input taken right after a finish item");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_stall)
        else $error("input open while a result appears");

endmodule

bind undirected_cycle_detect ucd_checker u_ucd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
);
